@@ hdl/pfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, widths and register map of the pixel footprint area block.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int COORD_W     = 32;
    localparam int COL_W       = 10;
    localparam int DEN_W       = 13;
    localparam int FAC_W       = 20;
    localparam int NUM_W       = 48;
    localparam int ABS_W       = 61;
    localparam int AREA_W      = 48;
    localparam int SIDE_W      = 32;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int DIV_BITS    = 3;
    localparam int DIV_STAGES  = NUM_W / DIV_BITS;
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_ITERS  = SIDE_W / SQRT_STAGES;

    localparam logic [DEN_W-1:0] SCALE_RST = 13'd256;
    localparam logic [DEN_W-1:0] RES_X_RST = 13'd320;
    localparam logic [DEN_W-1:0] RES_Y_RST = 13'd240;
    localparam logic [FAC_W-1:0] XZ_RST    = 20'd73400;
    localparam logic [FAC_W-1:0] YZ_RST    = 20'd55050;

    typedef enum logic [2:0] {
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_GRID_SCALE,
        REG_RESOLUTION_X,
        REG_RESOLUTION_Y,
        REG_XZ_FACTOR,
        REG_YZ_FACTOR
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic [DEN_W-1:0]          grid_scale;
        logic [DEN_W-1:0]          resolution_x;
        logic [DEN_W-1:0]          resolution_y;
        logic [FAC_W-1:0]          xz_factor;
        logic [FAC_W-1:0]          yz_factor;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]          pixel_col;
        logic [COL_W-1:0]          pixel_row;
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic [COORD_W-1:0]        world_depth;
    } in_t;

    typedef struct packed {
        logic [AREA_W-1:0] footprint_area;
        logic [SIDE_W-1:0] footprint_side;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] depth;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
        logic             neg;
    } axis_t;

    typedef struct packed {
        axis_t ax;
        axis_t ay;
        side_t side;
    } front_t;

    typedef struct packed {
        logic [NUM_W-1:0] qx;
        logic [NUM_W-1:0] qy;
        logic             negx;
        logic             negy;
        side_t            side;
    } quot_t;

    typedef struct packed {
        logic [1:0][ABS_W-1:0] a;
        logic                  zero;
    } delta_t;

endpackage
`default_nettype wire

@@ hdl/pfa_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_cfg
// APB register file holding offsets, scale, resolution and view factors.
// ----------------------------------------------------------------------------
module pfa_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfa_pkg::ADDR_W-1:0] paddr,
    input  logic [pfa_pkg::DATA_W-1:0] pwdata,
    output logic [pfa_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output pfa_pkg::cfg_t              cfg
);
    import pfa_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_OFFSET_X:     cfg_next.offset_x     = pwdata;
                REG_OFFSET_Y:     cfg_next.offset_y     = pwdata;
                REG_GRID_SCALE:   cfg_next.grid_scale   = pwdata[DEN_W-1:0];
                REG_RESOLUTION_X: cfg_next.resolution_x = pwdata[DEN_W-1:0];
                REG_RESOLUTION_Y: cfg_next.resolution_y = pwdata[DEN_W-1:0];
                REG_XZ_FACTOR:    cfg_next.xz_factor    = pwdata[FAC_W-1:0];
                REG_YZ_FACTOR:    cfg_next.yz_factor    = pwdata[FAC_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_y     <= '0;
            cfg_reg.grid_scale   <= SCALE_RST;
            cfg_reg.resolution_x <= RES_X_RST;
            cfg_reg.resolution_y <= RES_Y_RST;
            cfg_reg.xz_factor    <= XZ_RST;
            cfg_reg.yz_factor    <= YZ_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OFFSET_X:     prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:     prdata = cfg_reg.offset_y;
            REG_GRID_SCALE:   prdata = {{(DATA_W-DEN_W){1'b0}}, cfg_reg.grid_scale};
            REG_RESOLUTION_X: prdata = {{(DATA_W-DEN_W){1'b0}}, cfg_reg.resolution_x};
            REG_RESOLUTION_Y: prdata = {{(DATA_W-DEN_W){1'b0}}, cfg_reg.resolution_y};
            REG_XZ_FACTOR:    prdata = {{(DATA_W-FAC_W){1'b0}}, cfg_reg.xz_factor};
            REG_YZ_FACTOR:    prdata = {{(DATA_W-FAC_W){1'b0}}, cfg_reg.yz_factor};
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/pfa_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_front
// Corner position, scaling and centering: numerator and divisor per axis.
// ----------------------------------------------------------------------------
module pfa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  pfa_pkg::cfg_t   cfg,
    input  logic            up_valid,
    output logic            up_stall,
    input  pfa_pkg::in_t    up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output pfa_pkg::front_t dn_data
);
    import pfa_pkg::*;

    localparam int STAGES = 3;

    typedef struct packed {
        logic signed [34:0] sum_x;
        logic signed [34:0] sum_y;
        logic [DEN_W-1:0]   den_x;
        logic [DEN_W-1:0]   den_y;
        side_t              side;
    } s0_t;

    typedef struct packed {
        logic signed [48:0] cx;
        logic signed [48:0] cy;
        logic [DEN_W-1:0]   den_x;
        logic [DEN_W-1:0]   den_y;
        side_t              side;
    } s1_t;

    s0_t                s0_reg, s0_next;
    s1_t                s1_reg, s1_next;
    front_t             s2_reg, s2_next;
    logic [STAGES-1:0]  vld_reg, vld_next, rdy;
    logic [COL_W:0]     col_p1, row_p1;
    logic signed [49:0] hx, hy, cx50, cy50, dxa, dxb, dya, dyb;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !dn_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[STAGES-2:0], up_valid};
    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign dn_data  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        col_p1 = {1'b0, up_data.pixel_col} + 11'd1;
        row_p1 = {1'b0, up_data.pixel_row} + 11'd1;
        s0_next.sum_x = $signed({8'd0, col_p1, 16'd0})
                      + $signed({{3{cfg.offset_x[31]}}, cfg.offset_x});
        s0_next.sum_y = $signed({8'd0, row_p1, 16'd0})
                      + $signed({{3{cfg.offset_y[31]}}, cfg.offset_y});
        s0_next.den_x = (cfg.resolution_x == '0) ? 13'd1 : cfg.resolution_x;
        s0_next.den_y = (cfg.resolution_y == '0) ? 13'd1 : cfg.resolution_y;
        s0_next.side.px    = up_data.world_x;
        s0_next.side.py    = up_data.world_y;
        s0_next.side.depth = up_data.world_depth;
    end

    always_comb
    begin
        s1_next.cx    = s0_reg.sum_x * $signed({1'b0, cfg.grid_scale});
        s1_next.cy    = s0_reg.sum_y * $signed({1'b0, cfg.grid_scale});
        s1_next.den_x = s0_reg.den_x;
        s1_next.den_y = s0_reg.den_y;
        s1_next.side  = s0_reg.side;
    end

    always_comb
    begin
        hx   = $signed({14'd0, s1_reg.den_x, 23'd0});
        hy   = $signed({14'd0, s1_reg.den_y, 23'd0});
        cx50 = $signed({s1_reg.cx[48], s1_reg.cx});
        cy50 = $signed({s1_reg.cy[48], s1_reg.cy});
        dxa  = cx50 - hx;
        dxb  = hx - cx50;
        dya  = hy - cy50;
        dyb  = cy50 - hy;
        s2_next.ax.neg = dxa[49];
        s2_next.ax.mag = dxa[49] ? dxb[NUM_W-1:0] : dxa[NUM_W-1:0];
        s2_next.ax.den = s1_reg.den_x;
        s2_next.ay.neg = dya[49];
        s2_next.ay.mag = dya[49] ? dyb[NUM_W-1:0] : dya[NUM_W-1:0];
        s2_next.ay.den = s1_reg.den_y;
        s2_next.side   = s1_reg.side;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s0_reg <= s0_next;
        end
        if (rdy[1])
        begin
            s1_reg <= s1_next;
        end
        if (rdy[2])
        begin
            s2_reg <= s2_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pfa_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_div
// Pipelined restoring divider, both axes side by side, three bits a stage.
// ----------------------------------------------------------------------------
module pfa_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  pfa_pkg::front_t up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output pfa_pkg::quot_t  dn_data
);
    import pfa_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] qn;
        logic [DEN_W-1:0] den;
    } lane_t;

    typedef struct packed {
        lane_t lx;
        lane_t ly;
        logic  negx;
        logic  negy;
        side_t side;
    } stage_t;

    stage_t                stage_reg [DIV_STAGES];
    stage_t                src       [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg, vld_next, rdy;

    function automatic lane_t div_step(lane_t l);
        lane_t          o;
        logic [DEN_W:0] r;
        logic           qb;
        o = l;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            r = {o.rem, o.qn[NUM_W-1]};
            if (r >= {1'b0, o.den})
            begin
                r    = r - {1'b0, o.den};
                qb   = 1'b1;
            end
            else
            begin
                qb   = 1'b0;
            end
            o.rem = r[DEN_W-1:0];
            o.qn  = {o.qn[NUM_W-2:0], qb};
        end
        return o;
    endfunction

    always_comb
    begin
        rdy[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || !dn_stall;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[DIV_STAGES-2:0], up_valid};
    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        src[0].lx.rem = '0;
        src[0].lx.qn  = up_data.ax.mag;
        src[0].lx.den = up_data.ax.den;
        src[0].ly.rem = '0;
        src[0].ly.qn  = up_data.ay.mag;
        src[0].ly.den = up_data.ay.den;
        src[0].negx   = up_data.ax.neg;
        src[0].negy   = up_data.ay.neg;
        src[0].side   = up_data.side;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            src[k] = stage_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (rdy[k])
            begin
                stage_reg[k].lx   <= div_step(src[k].lx);
                stage_reg[k].ly   <= div_step(src[k].ly);
                stage_reg[k].negx <= src[k].negx;
                stage_reg[k].negy <= src[k].negy;
                stage_reg[k].side <= src[k].side;
            end
        end
    end

    assign dn_data.qx   = stage_reg[DIV_STAGES-1].lx.qn;
    assign dn_data.qy   = stage_reg[DIV_STAGES-1].ly.qn;
    assign dn_data.negx = stage_reg[DIV_STAGES-1].negx;
    assign dn_data.negy = stage_reg[DIV_STAGES-1].negy;
    assign dn_data.side = stage_reg[DIV_STAGES-1].side;

endmodule
`default_nettype wire

@@ hdl/pfa_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_mul
// Depth and view-factor scaling, sign, difference to the point, magnitude.
// ----------------------------------------------------------------------------
module pfa_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  pfa_pkg::cfg_t   cfg,
    input  logic            up_valid,
    output logic            up_stall,
    input  pfa_pkg::quot_t  up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output pfa_pkg::delta_t dn_data
);
    import pfa_pkg::*;

    localparam int STAGES = 6;

    typedef struct packed {
        logic [1:0][55:0]        plo;
        logic [1:0][55:0]        phi;
        logic [1:0]              neg;
        logic [1:0][COORD_W-1:0] p;
        logic                    zero;
    } m0_t;

    typedef struct packed {
        logic [1:0][55:0]        t;
        logic [1:0]              neg;
        logic [1:0][COORD_W-1:0] p;
        logic                    zero;
    } m1_t;

    typedef struct packed {
        logic [1:0][47:0]        flo;
        logic [1:0][47:0]        fhi;
        logic [1:0]              neg;
        logic [1:0][COORD_W-1:0] p;
        logic                    zero;
    } m2_t;

    typedef struct packed {
        logic [1:0][59:0]        w;
        logic [1:0]              neg;
        logic [1:0][COORD_W-1:0] p;
        logic                    zero;
    } m3_t;

    typedef struct packed {
        logic [1:0][61:0] d;
        logic             zero;
    } m4_t;

    m0_t                   m0_reg, m0_next;
    m1_t                   m1_reg, m1_next;
    m2_t                   m2_reg, m2_next;
    m3_t                   m3_reg, m3_next;
    m4_t                   m4_reg, m4_next;
    delta_t                m5_reg, m5_next;
    logic [STAGES-1:0]     vld_reg, vld_next, rdy;
    logic [1:0][NUM_W-1:0] q;
    logic [1:0][FAC_W-1:0] fac;
    logic [1:0][61:0]      ws, ps, nd;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !dn_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[STAGES-2:0], up_valid};
    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign dn_data  = m5_reg;
    assign q        = {up_data.qy, up_data.qx};
    assign fac      = {cfg.yz_factor, cfg.xz_factor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        m0_next.neg  = {up_data.negy, up_data.negx};
        m0_next.p    = {up_data.side.py, up_data.side.px};
        m0_next.zero = (up_data.side.depth == '0);
        m1_next.neg  = m0_reg.neg;
        m1_next.p    = m0_reg.p;
        m1_next.zero = m0_reg.zero;
        m2_next.neg  = m1_reg.neg;
        m2_next.p    = m1_reg.p;
        m2_next.zero = m1_reg.zero;
        m3_next.neg  = m2_reg.neg;
        m3_next.p    = m2_reg.p;
        m3_next.zero = m2_reg.zero;
        m4_next.zero = m3_reg.zero;
        m5_next.zero = m4_reg.zero;
        for (int l = 0; l < 2; l++)
        begin
            m0_next.plo[l] = q[l][23:0] * up_data.side.depth;
            m0_next.phi[l] = q[l][47:24] * up_data.side.depth;
            m1_next.t[l]   = m0_reg.phi[l] + {24'd0, m0_reg.plo[l][55:24]};
            m2_next.flo[l] = m1_reg.t[l][27:0] * fac[l];
            m2_next.fhi[l] = m1_reg.t[l][55:28] * fac[l];
            m3_next.w[l]   = {m2_reg.fhi[l], 12'd0} + {28'd0, m2_reg.flo[l][47:16]};
            ws[l]          = {2'd0, m3_reg.w[l]};
            ps[l]          = {{30{m3_reg.p[l][COORD_W-1]}}, m3_reg.p[l]};
            m4_next.d[l]   = m3_reg.neg[l] ? (62'd0 - ws[l] - ps[l]) : (ws[l] - ps[l]);
            nd[l]          = 62'd0 - m4_reg.d[l];
            m5_next.a[l]   = m4_reg.d[l][61] ? nd[l][ABS_W-1:0] : m4_reg.d[l][ABS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            m0_reg <= m0_next;
        end
        if (rdy[1])
        begin
            m1_reg <= m1_next;
        end
        if (rdy[2])
        begin
            m2_reg <= m2_next;
        end
        if (rdy[3])
        begin
            m3_reg <= m3_next;
        end
        if (rdy[4])
        begin
            m4_reg <= m4_next;
        end
        if (rdy[5])
        begin
            m5_reg <= m5_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pfa_area.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_area
// Product of the deltas with saturation, then a two-bit-a-stage square root.
// ----------------------------------------------------------------------------
module pfa_area (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  pfa_pkg::delta_t up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output pfa_pkg::out_t   dn_data
);
    import pfa_pkg::*;

    localparam int STAGES = SQRT_STAGES + 2;

    typedef struct packed {
        logic [63:0] p00;
        logic [60:0] p01;
        logic [60:0] p10;
        logic [57:0] p11;
        logic        zero;
    } pp_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [63:0]       rad;
        logic [33:0]       rem;
        logic [SIDE_W-1:0] root;
    } sq_t;

    pp_t               pp_reg, pp_next;
    sq_t               sq_reg [SQRT_STAGES+1];
    sq_t               sq_next;
    logic [STAGES-1:0] vld_reg, vld_next, rdy;
    logic [94:0]       sum;
    logic              ovf;

    function automatic sq_t sqrt_step(sq_t s);
        sq_t         o;
        logic [35:0] r;
        logic [35:0] trial;
        o = s;
        for (int j = 0; j < SQRT_ITERS; j++)
        begin
            r     = {o.rem, o.rad[63:62]};
            trial = {2'd0, o.root, 2'b01};
            o.rad = {o.rad[61:0], 2'b00};
            if (r >= trial)
            begin
                r      = r - trial;
                o.root = {o.root[SIDE_W-2:0], 1'b1};
            end
            else
            begin
                o.root = {o.root[SIDE_W-2:0], 1'b0};
            end
            o.rem = r[33:0];
        end
        return o;
    endfunction

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !dn_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[STAGES-2:0], up_valid};
    assign up_stall = !rdy[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign dn_data.footprint_area = sq_reg[SQRT_STAGES].area;
    assign dn_data.footprint_side = sq_reg[SQRT_STAGES].root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        pp_next.p00  = up_data.a[0][31:0] * up_data.a[1][31:0];
        pp_next.p01  = up_data.a[0][31:0] * up_data.a[1][60:32];
        pp_next.p10  = up_data.a[0][60:32] * up_data.a[1][31:0];
        pp_next.p11  = up_data.a[0][60:32] * up_data.a[1][60:32];
        pp_next.zero = up_data.zero;
    end

    always_comb
    begin
        sum = {31'd0, pp_reg.p00} + {2'd0, pp_reg.p01, 32'd0} + {2'd0, pp_reg.p10, 32'd0};
        ovf = (|pp_reg.p11) || (|sum[94:64]);
        if (pp_reg.zero)
        begin
            sq_next.area = '0;
        end
        else if (ovf)
        begin
            sq_next.area = '1;
        end
        else
        begin
            sq_next.area = sum[63:16];
        end
        sq_next.rad  = {sq_next.area, 16'd0};
        sq_next.rem  = '0;
        sq_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pp_reg <= pp_next;
        end
        if (rdy[1])
        begin
            sq_reg[0] <= sq_next;
        end
        for (int k = 1; k <= SQRT_STAGES; k++)
        begin
            if (rdy[k+1])
            begin
                sq_reg[k] <= sqrt_step(sq_reg[k-1]);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/pixel_footprint_area.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_footprint_area
// Per-pixel world footprint area and its square root.
// Throughput: one beat per cycle while result_stall is low, set by the
// 16-stage divider and the 16-stage square root, both fully pipelined;
// stalls collapse bubbles. Reset clears all valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
module pixel_footprint_area (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  pfa_pkg::in_t               pixel,
    output logic                       result_valid,
    input  logic                       result_stall,
    output pfa_pkg::out_t              result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfa_pkg::ADDR_W-1:0] paddr,
    input  logic [pfa_pkg::DATA_W-1:0] pwdata,
    output logic [pfa_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pfa_pkg::*;

    cfg_t   cfg;
    front_t front_data;
    quot_t  quot_data;
    delta_t delta_data;
    logic   front_valid, front_stall;
    logic   quot_valid, quot_stall;
    logic   delta_valid, delta_stall;

    pfa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (pixel_valid),
        .up_stall (pixel_stall),
        .up_data  (pixel),
        .dn_valid (front_valid),
        .dn_stall (front_stall),
        .dn_data  (front_data)
    );

    pfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_stall (front_stall),
        .up_data  (front_data),
        .dn_valid (quot_valid),
        .dn_stall (quot_stall),
        .dn_data  (quot_data)
    );

    pfa_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (quot_valid),
        .up_stall (quot_stall),
        .up_data  (quot_data),
        .dn_valid (delta_valid),
        .dn_stall (delta_stall),
        .dn_data  (delta_data)
    );

    pfa_area u_area (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (delta_valid),
        .up_stall (delta_stall),
        .up_data  (delta_data),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .dn_data  (result)
    );

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pixel_stall)
        else $error("pixel stalled while result stage empty");

    a_zero_area_side: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.footprint_area == '0) |-> result.footprint_side == '0)
        else $error("nonzero side for zero area");

    a_side_low: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        ({32'd0, result.footprint_side} * {32'd0, result.footprint_side})
            <= {result.footprint_area, 16'd0})
        else $error("side too large");

    a_side_high: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        (({33'd0, result.footprint_side} + 65'd1) * ({33'd0, result.footprint_side} + 65'd1))
            > {17'd0, result.footprint_area, 16'd0})
        else $error("side too small");

endmodule
`default_nettype wire

@@ bench/pixel_footprint_area_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_footprint_area_test
// Drives pixel beats with random gaps and random result stalls. A local
// predictor of the footprint area and side is checked beat by beat against
// the block's results. Registers are rewritten over the APB port between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module pixel_footprint_area_test;
    import pfa_pkg::*;

    localparam int          LATENCY     = 43;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [47:0] AREA_SAT    = 48'hFFFF_FFFF_FFFF;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                pixel_valid  = 1'b0;
    logic                pixel_stall;
    in_t                 pixel        = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    out_t                result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cfg_t  regs;
    out_t  footprint_q[$];
    int    mismatches  = 0;
    int    cycles      = 0;
    int    stall_left  = 0;
    bit    gaps_on     = 1'b1;

    pixel_footprint_area dut (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint corner_world(logic [9:0] pos, logic [31:0] off,
                                            logic [12:0] res_in, bit flip,
                                            logic [31:0] depth, logic [19:0] fac);
        longint       corner;
        longint       half;
        longint       d;
        logic [63:0]  res;
        logic [63:0]  mag;
        logic [63:0]  n;
        logic [127:0] t;
        logic [63:0]  w;
        res    = (res_in == 0) ? 64'd1 : {51'd0, res_in};
        corner = (longint'({54'd0, pos}) + 1) * 65536 + longint'($signed(off));
        corner = corner * longint'({51'd0, regs.grid_scale});
        half   = longint'(res) * 8388608;
        d      = flip ? half - corner : corner - half;
        mag    = (d < 0) ? 64'(-d) : 64'(d);
        n      = mag / res;
        t      = {64'd0, n} * {96'd0, depth};
        w      = t[87:24];
        t      = {64'd0, w} * {108'd0, fac};
        w      = t[79:16];
        return (d < 0) ? -longint'(w) : longint'(w);
    endfunction

    function automatic out_t footprint(in_t p);
        out_t         o;
        longint       dx;
        longint       dy;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [127:0] prod;
        logic [63:0]  area;
        logic [63:0]  root;
        o = '0;
        if (p.world_depth == 0)
            return o;
        dx = corner_world(p.pixel_col, regs.offset_x, regs.resolution_x, 1'b0,
                          p.world_depth, regs.xz_factor) - longint'(p.world_x);
        dy = corner_world(p.pixel_row, regs.offset_y, regs.resolution_y, 1'b1,
                          p.world_depth, regs.yz_factor) - longint'(p.world_y);
        ax   = (dx < 0) ? 64'(-dx) : 64'(dx);
        ay   = (dy < 0) ? 64'(-dy) : 64'(dy);
        prod = {64'd0, ax} * {64'd0, ay};
        area = (prod[127:64] != 0) ? {16'd0, AREA_SAT} : prod[79:16];
        root = isqrt(area << 16);
        o.footprint_area = area[47:0];
        o.footprint_side = root[31:0];
        return o;
    endfunction

    // result side: check each beat, draw a stall count after it
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (footprint_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = footprint_q.pop_front();
                if (result.footprint_area !== want.footprint_area)
                begin
                    $error("footprint_area expected %0d actual %0d",
                           want.footprint_area, result.footprint_area);
                    mismatches++;
                end
                if (result.footprint_side !== want.footprint_side)
                begin
                    $error("footprint_side expected %0d actual %0d",
                           want.footprint_side, result.footprint_side);
                    mismatches++;
                end
            end
            stall_left = gaps_on ? $urandom_range(0, 15) : 0;
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic send_pixel(in_t p);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (!(pixel_valid && !pixel_stall));
        footprint_q = {footprint_q, footprint(p)};
    endtask

    task automatic drain;
        pixel_valid <= 1'b0;
        while (footprint_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OFFSET_X:     regs.offset_x     = value;
            REG_OFFSET_Y:     regs.offset_y     = value;
            REG_GRID_SCALE:   regs.grid_scale   = value[12:0];
            REG_RESOLUTION_X: regs.resolution_x = value[12:0];
            REG_RESOLUTION_Y: regs.resolution_y = value[12:0];
            REG_XZ_FACTOR:    regs.xz_factor    = value[19:0];
            REG_YZ_FACTOR:    regs.yz_factor    = value[19:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [31:0] ox, logic [31:0] oy, logic [12:0] sc,
                             logic [12:0] rx, logic [12:0] ry,
                             logic [19:0] fx, logic [19:0] fy);
        apb_write(REG_OFFSET_X, ox);
        apb_write(REG_OFFSET_Y, oy);
        apb_write(REG_GRID_SCALE, {19'd0, sc});
        apb_write(REG_RESOLUTION_X, {19'd0, rx});
        apb_write(REG_RESOLUTION_Y, {19'd0, ry});
        apb_write(REG_XZ_FACTOR, {12'd0, fx});
        apb_write(REG_YZ_FACTOR, {12'd0, fy});
        @(posedge clk);
    endtask

    function automatic in_t make_pixel(logic [9:0] c, logic [9:0] r, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z);
        in_t p;
        p.pixel_col   = c;
        p.pixel_row   = r;
        p.world_x     = x;
        p.world_y     = y;
        p.world_depth = z;
        return p;
    endfunction

    function automatic in_t random_pixel();
        in_t p;
        p.pixel_col = 10'($urandom());
        p.pixel_row = 10'($urandom());
        p.world_x   = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24)
                      - (1 << 23);
        p.world_y   = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24)
                      - (1 << 23);
        case ($urandom_range(0, 9))
            0:       p.world_depth = 0;
            1, 2:    p.world_depth = $urandom();
            default: p.world_depth = $urandom_range(1, 10000 << 16);
        endcase
        return p;
    endfunction

    task automatic test_defaults;
        send_pixel(make_pixel(10'd0, 10'd0, 32'd0, 32'd0, 32'd1000 << 16));
        send_pixel(make_pixel(10'd1023, 10'd1023, 32'd0, 32'd0, 32'd1000 << 16));
        send_pixel(make_pixel(10'd160, 10'd120, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1));
        send_pixel(make_pixel(10'd5, 10'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_pixel(make_pixel(10'd300, 10'd200, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0));
        send_pixel(make_pixel(10'd319, 10'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        drain();
    endtask

    task automatic test_extremes;
        // area overflow: widest factors, deepest point, far offsets
        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 13'd4096, 13'd1, 13'd1,
                  20'hFFFFF, 20'hFFFFF);
        send_pixel(make_pixel(10'd1023, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'hFFFF_FFFF));
        send_pixel(make_pixel(10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_pixel(make_pixel(10'd512, 10'd512, 32'd0, 32'd0, 32'd1));
        drain();
        // zero resolution and zero scale
        load_regs(32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd0, 13'd0, 20'd0, 20'd0);
        send_pixel(make_pixel(10'd3, 10'd4, 32'h0001_0000, 32'hFFFF_0000, 32'd500 << 16));
        send_pixel(make_pixel(10'd1023, 10'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        drain();
        load_regs(0, 0, 13'h1FFF, 13'h1FFF, 13'h1FFF, 20'd1, 20'd1);
        send_pixel(make_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
        send_pixel(make_pixel(10'd0, 10'd1023, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
        send_pixel(make_pixel(10'h2AA, 10'h155, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'h5555_5555));
        drain();
        // write to an unused address leaves every register alone
        psel    <= 1'b1;
        paddr   <= 5'd28;
        pwdata  <= $urandom();
        pwrite  <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        send_pixel(make_pixel(10'd17, 10'd9, 32'd0, 32'd0, 32'd200 << 16));
        drain();
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 6; phase++)
        begin
            gaps_on = (phase != 2);
            load_regs($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 64 << 16),
                      $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 64 << 16),
                      13'($urandom_range(0, 7) == 0 ? $urandom()
                                                    : $urandom_range(256, 4096)),
                      13'($urandom_range(0, 7) == 0 ? $urandom()
                                                    : $urandom_range(1, 4096)),
                      13'($urandom_range(0, 7) == 0 ? $urandom()
                                                    : $urandom_range(1, 4096)),
                      20'($urandom()), 20'($urandom()));
            repeat (140)
                send_pixel(random_pixel());
            drain();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        regs.offset_x     = 0;
        regs.offset_y     = 0;
        regs.grid_scale   = SCALE_RST;
        regs.resolution_x = RES_X_RST;
        regs.resolution_y = RES_Y_RST;
        regs.xz_factor    = XZ_RST;
        regs.yz_factor    = YZ_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_random();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
